/* sv/ipr_pkg.sv */
// Shared types, codes and sizes for the IP reassembly context table.
package ipr_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > 4) ? CNT_W : 4;
  localparam int RS_W    = (IDX_W > 3) ? IDX_W : 3;
  localparam int BYTES_W = 20;

  localparam logic [1:0] OP_FRAG = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_REL  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_BIG    = 3'd1;
  localparam logic [2:0] ST_MEMORY     = 3'd2;
  localparam logic [2:0] ST_TOO_MANY   = 3'd3;
  localparam logic [2:0] ST_NO_CONTEXT = 3'd4;

  localparam logic [2:0] CFG_MAX_CTX  = 3'd0;
  localparam logic [2:0] CFG_MAX_PKT  = 3'd1;
  localparam logic [2:0] CFG_MEM_CAP  = 3'd2;
  localparam logic [2:0] CFG_EXPIRY   = 3'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] packet_ident;
    logic [7:0]  protocol;
    logic [15:0] frag_offset;
    logic [15:0] payload_length;
    logic [31:0] time_now;
    logic [2:0]  release_slot;
  } ipr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] assembled_length;
    logic        new_context;
    logic [3:0]  expired_count;
    logic [18:0] bytes_in_use;
  } ipr_out_t;

  // Record that walks down the cell row with a request.
  typedef struct packed {
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic [15:0]        hit_len;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [CNT_W-1:0]   drop_cnt;
    logic [BYTES_W-1:0] drop_bytes;
  } ipr_rec_t;

  // Entry update broadcast to the cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             set_valid;
    logic [63:0]      pair;
    logic [23:0]      idp;
    logic [15:0]      len;
    logic [31:0]      expiry;
  } ipr_wr_t;

endpackage

/* sv/ip_reassembly_context_table_core.sv */
// Top level of the IP reassembly context table: request control, totals and result register.
//
// Requests enter on in_valid/in_stall with one ipr_in_t per request: a fragment
// header (find or open a context, refresh expiry, grow length), a time tick
// (drop contexts whose expiry is before time_now) or a release of one slot.
// Each request produces exactly one ipr_out_t on out_valid/out_stall.
// The request walks a row of ENTRIES slot cells, one cell per cycle, gathering
// the match, the first free slot and tick drops; the apply state then decides
// and writes the chosen slot, and the result waits in the hold state until the
// output register takes it; no new request is taken before then.
// in_stall is high from acceptance until the result enters the output
// register. When out_stall holds the output register, the finished result
// waits and the next request is not taken.
// cfg_we writes registers 0..3 (max contexts, max packet length, memory cap,
// expiry seconds); other indexes are ignored. Write only while idle.
// Reset (synchronous, rst_n low) empties the table, clears the byte and
// context totals and loads the default configuration; no clearing pass.
module ip_reassembly_context_table_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ipr_pkg::ipr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ipr_pkg::ipr_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [18:0]       cfg_wdata
);
  import ipr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_APPLY, S_HOLD} state_t;

  state_t             state_r;
  ipr_in_t            req_r;
  logic               start_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [CNT_W-1:0]   count_r;
  logic [3:0]         max_ctx_r;
  logic [15:0]        max_pkt_r;
  logic [18:0]        cap_r;
  logic [15:0]        exp_sec_r;
  ipr_out_t           res_r;
  logic               out_valid_r;
  ipr_out_t           out_data_r;

  logic               tok   [ENTRIES+1];
  ipr_rec_t           rec   [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES:0]   tok_vec;

  ipr_wr_t            wr;
  ipr_out_t           res_nxt;
  logic [BYTES_W-1:0] bytes_nxt;
  logic [CNT_W-1:0]   count_nxt;

  logic               in_acc;
  logic               out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign tok[0] = start_r;
  assign rec[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ipr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .req      (req_r),
      .tok_in   (tok[i]),
      .rec_in   (rec[i]),
      .wr       (wr),
      .tok_out  (tok[i+1]),
      .rec_out  (rec[i+1]),
      .valid_o  (valid_vec[i])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_tok
    assign tok_vec[i] = tok[i];
  end

  // Decide and update once the record has left the last cell.
  always_comb begin
    ipr_rec_t           rc;
    logic [16:0]        ext;
    logic [15:0]        old_len;
    logic               hit;
    logic               no_room;
    logic [IDX_W-1:0]   target;
    logic               grow;
    logic               too_big;
    logic               mem_err;
    logic [BYTES_W:0]   new_total;

    rc        = rec[ENTRIES];
    ext       = {1'b0, req_r.frag_offset} + {1'b0, req_r.payload_length};
    hit       = rc.hit_found;
    old_len   = hit ? rc.hit_len : 16'd0;
    no_room   = !hit && ((CMP_W'(count_r) >= CMP_W'(max_ctx_r)) || !rc.free_found);
    target    = hit ? rc.hit_idx : rc.free_idx;
    grow      = ext > {1'b0, old_len};
    too_big   = grow && (ext > {1'b0, max_pkt_r});
    new_total = {1'b0, bytes_r} - {{(BYTES_W-15){1'b0}}, old_len}
              + {{(BYTES_W-16){1'b0}}, ext};
    mem_err   = grow && (new_total > {{(BYTES_W-18){1'b0}}, cap_r});

    wr        = '0;
    wr.idx    = target;
    wr.pair   = {req_r.source_address, req_r.dest_address};
    wr.idp    = {req_r.packet_ident, req_r.protocol};
    wr.len    = grow ? ext[15:0] : old_len;
    wr.expiry = req_r.time_now + {16'd0, exp_sec_r};
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    res_nxt   = '0;
    res_nxt.status = ST_OK;

    unique case (req_r.op)
      OP_FRAG: begin
        if (no_room) begin
          res_nxt.status = ST_TOO_MANY;
        end else if (too_big || mem_err) begin
          // free the context; a fresh one was never marked valid
          res_nxt.status      = too_big ? ST_TOO_BIG : ST_MEMORY;
          res_nxt.slot        = 3'(target);
          res_nxt.new_context = !hit;
          if (hit) begin
            wr.en     = 1'b1;
            bytes_nxt = BYTES_W'(bytes_r - {{(BYTES_W-16){1'b0}}, old_len});
            count_nxt = CNT_W'(count_r - 1'b1);
          end
        end else begin
          wr.en                    = 1'b1;
          wr.set_valid             = 1'b1;
          res_nxt.slot             = 3'(target);
          res_nxt.assembled_length = wr.len;
          res_nxt.new_context      = !hit;
          if (grow) begin
            bytes_nxt = new_total[BYTES_W-1:0];
          end
          if (!hit) begin
            count_nxt = CNT_W'(count_r + 1'b1);
          end
        end
      end
      OP_TICK: begin
        bytes_nxt             = BYTES_W'(bytes_r - rc.drop_bytes);
        count_nxt             = CNT_W'(count_r - rc.drop_cnt);
        res_nxt.expired_count = 4'(rc.drop_cnt);
      end
      OP_REL: begin
        res_nxt.slot = req_r.release_slot;
        if (hit) begin
          wr.en     = 1'b1;
          bytes_nxt = BYTES_W'(bytes_r - {{(BYTES_W-16){1'b0}}, old_len});
          count_nxt = CNT_W'(count_r - 1'b1);
        end else begin
          res_nxt.status = ST_NO_CONTEXT;
        end
      end
      default: begin
      end
    endcase

    if (state_r != S_APPLY) begin
      wr.en = 1'b0;
    end
    res_nxt.bytes_in_use = bytes_nxt[18:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      bytes_r     <= '0;
      count_r     <= '0;
      max_ctx_r   <= 4'd4;
      max_pkt_r   <= 16'd4096;
      cap_r       <= 19'd16384;
      exp_sec_r   <= 16'd10;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_acc;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_CTX: max_ctx_r <= cfg_wdata[3:0];
          CFG_MAX_PKT: max_pkt_r <= cfg_wdata[15:0];
          CFG_MEM_CAP: cap_r     <= cfg_wdata;
          CFG_EXPIRY:  exp_sec_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r   <= in_data;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok[ENTRIES]) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          bytes_r <= bytes_nxt;
          count_r <= count_nxt;
          res_r   <= res_nxt;
          state_r <= S_HOLD;
        end
        S_HOLD: begin
          // hold the result until the output register frees up
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (int'(count_r) == $countones(valid_vec)))
    else $error("context count disagrees with valid slots");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one request in the cell row");

  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_WALK) && start_r)
    else $error("accepted request did not start a walk");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result presented outside hold state");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $past(tok[ENTRIES]))
    else $error("apply without finished walk");

endmodule

/* sv/ipr_cell.sv */
// One context slot of the table, with the walk stage that passes the request record on.
module ipr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ipr_pkg::IDX_W-1:0]  cell_idx,
  input  ipr_pkg::ipr_in_t           req,
  input  logic                       tok_in,
  input  ipr_pkg::ipr_rec_t          rec_in,
  input  ipr_pkg::ipr_wr_t           wr,
  output logic                       tok_out,
  output ipr_pkg::ipr_rec_t          rec_out,
  output logic                       valid_o
);
  import ipr_pkg::*;

  logic        valid_r;
  logic [63:0] pair_r;
  logic [23:0] idp_r;
  logic [15:0] len_r;
  logic [31:0] exp_r;
  logic        tok_r;
  ipr_rec_t    rec_r;
  ipr_rec_t    rec_nxt;
  logic        drop_now;
  logic        key_hit;
  logic        rel_hit;
  logic        wr_me;

  assign key_hit = valid_r && (pair_r == {req.source_address, req.dest_address}) &&
                   (idp_r == {req.packet_ident, req.protocol});
  assign rel_hit = valid_r && (RS_W'(cell_idx) == RS_W'(req.release_slot));
  assign wr_me   = wr.en && (wr.idx == cell_idx);

  always_comb begin
    rec_nxt  = rec_in;
    drop_now = 1'b0;
    unique case (req.op)
      OP_FRAG: begin
        if (key_hit && !rec_in.hit_found) begin
          rec_nxt.hit_found = 1'b1;
          rec_nxt.hit_idx   = cell_idx;
          rec_nxt.hit_len   = len_r;
        end
        if (!valid_r && !rec_in.free_found) begin
          rec_nxt.free_found = 1'b1;
          rec_nxt.free_idx   = cell_idx;
        end
      end
      OP_TICK: begin
        // expire strictly before now
        if (valid_r && (req.time_now > exp_r)) begin
          drop_now           = 1'b1;
          rec_nxt.drop_cnt   = CNT_W'(rec_in.drop_cnt + 1'b1);
          rec_nxt.drop_bytes = BYTES_W'(rec_in.drop_bytes + {{(BYTES_W-16){1'b0}}, len_r});
        end
      end
      OP_REL: begin
        if (rel_hit) begin
          rec_nxt.hit_found = 1'b1;
          rec_nxt.hit_idx   = cell_idx;
          rec_nxt.hit_len   = len_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (tok_in && drop_now) begin
        valid_r <= 1'b0;
      end else if (wr_me) begin
        valid_r <= wr.set_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      rec_r <= rec_nxt;
    end
    if (wr_me && wr.set_valid) begin
      pair_r <= wr.pair;
      idp_r  <= wr.idp;
      len_r  <= wr.len;
      exp_r  <= wr.expiry;
    end
  end

  assign tok_out = tok_r;
  assign rec_out = rec_r;
  assign valid_o = valid_r;

endmodule
